### hdl/pft_pkg.sv
`timescale 1ns / 1ps

package pft_pkg;

	// Text bytes with a special meaning
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_POUND = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// Room for the results of one input byte; a byte causes at most five
	localparam int unsigned LIST_DEPTH = 6;
	localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_DATA  = 2'd1,
		EV_END   = 2'd2,
		EV_DONE  = 2'd3
	} ev_t;

	typedef enum logic [2:0] {
		K_WS    = 3'd0,
		K_BANG  = 3'd1,
		K_POUND = 3'd2,
		K_KEY   = 3'd3,
		K_SEP   = 3'd4,
		K_VAL   = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		M_START = 4'd0,
		M_WS    = 4'd1,
		M_BANG  = 4'd2,
		M_POUND = 4'd3,
		M_KEY   = 4'd4,
		M_KSP   = 4'd5,
		M_SEP2  = 4'd6,
		M_SEP3  = 4'd7,
		M_VALUE = 4'd8,
		M_DONE  = 4'd9
	} mode_t;

	typedef struct packed {
		ev_t        ev;
		kind_t      kind;
		logic [7:0] data;
	} entry_t;

	typedef entry_t [LIST_DEPTH-1:0] res_list_t;

	// Decoder result for one byte: event list plus the parser state it leaves
	typedef struct packed {
		res_list_t          list;
		logic [CNT_W-1:0]   cnt;
		mode_t              mode;
		logic               esc;
	} dec_t;

	// Build one event; data is zero except on content events
	function automatic entry_t mk_entry(ev_t ev, kind_t kind, logic [7:0] b);
		entry_t e;
		e.ev   = ev;
		e.kind = kind;
		e.data = (ev == EV_DATA) ? b : 8'h00;
		return e;
	endfunction

endpackage

### hdl/pft_decode.sv
`timescale 1ns / 1ps

module pft_decode
	import pft_pkg::*;
(
	input  mode_t      mode,
	input  logic       esc,
	input  logic [7:0] text_byte,
	input  logic       end_of_input,
	output dec_t       dec
);

	always_comb begin
		res_list_t        lst;
		logic [CNT_W-1:0] n;
		mode_t            nmode;
		logic             nesc;
		logic             z;
		logic             ws;
		logic             eol;
		logic             eqcol;
		logic             disp;
		logic             fin;
		logic             ov;
		logic             vb;
		logic             e_l;
		kind_t            ck;

		lst   = '0;
		n     = '0;
		nmode = mode;
		nesc  = esc;
		z     = end_of_input || (text_byte == CH_NUL);
		ws    = text_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		eol   = text_byte inside {CH_LF, CH_CR};
		eqcol = text_byte inside {CH_EQ, CH_COLON};
		disp  = 1'b0;
		fin   = 1'b0;
		ov    = 1'b0;
		vb    = 1'b0;
		e_l   = esc;
		ck    = (mode == M_BANG) ? K_BANG : K_POUND;

		// Per-mode handling up to the point where a shared tail takes over
		case (mode)
			M_START: begin
				disp = 1'b1;
			end
			M_WS: begin
				if (!z && ws) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_WS, text_byte); n = n + 1'b1;
				end else begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_WS, text_byte); n = n + 1'b1;
					disp = 1'b1;
				end
			end
			M_BANG, M_POUND: begin
				if (z) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, ck, text_byte); n = n + 1'b1;
					fin = 1'b1;
				end else if (eol) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, ck, text_byte); n = n + 1'b1;
					disp = 1'b1;
				end else begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, ck, text_byte); n = n + 1'b1;
				end
			end
			M_KEY: begin
				if (esc) begin
					if (z) begin
						lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_KEY, text_byte); n = n + 1'b1;
						fin = 1'b1;
					end else begin
						nesc = 1'b0;
						lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_KEY, text_byte); n = n + 1'b1;
					end
				end else if (z) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_KEY, text_byte); n = n + 1'b1;
					fin = 1'b1;
				end else if (text_byte == CH_SPACE) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_KEY, text_byte); n = n + 1'b1;
					lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_SEP, text_byte); n = n + 1'b1;
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_SEP, text_byte); n = n + 1'b1;
					nmode = M_KSP;
				end else if (eqcol) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_KEY, text_byte); n = n + 1'b1;
					lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_SEP, text_byte); n = n + 1'b1;
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_SEP, text_byte); n = n + 1'b1;
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_SEP, text_byte); n = n + 1'b1;
					lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_VAL, text_byte); n = n + 1'b1;
					nmode = M_VALUE;
				end else if (eol) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_KEY, text_byte); n = n + 1'b1;
					disp = 1'b1;
				end else if (text_byte == CH_BSL) begin
					nesc = 1'b1;
				end else begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_KEY, text_byte); n = n + 1'b1;
				end
			end
			M_KSP: begin
				if (!z && eqcol) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_SEP, text_byte); n = n + 1'b1;
					nmode = M_SEP2;
				end else begin
					ov = 1'b1;
				end
			end
			M_SEP2, M_SEP3: begin
				if (z || eol) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_SEP, text_byte); n = n + 1'b1;
					disp = 1'b1;
				end else if (mode == M_SEP2 && text_byte == CH_SPACE) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_SEP, text_byte); n = n + 1'b1;
					nmode = M_SEP3;
				end else begin
					ov = 1'b1;
				end
			end
			M_VALUE: begin
				vb = 1'b1;
			end
			default: begin
				// parse done and unused codes: swallow the byte
				nmode = M_DONE;
				nesc  = 1'b0;
			end
		endcase

		// Close the separator and open the value
		if (ov) begin
			lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_SEP, text_byte); n = n + 1'b1;
			lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_VAL, text_byte); n = n + 1'b1;
			e_l  = 1'b0;
			nesc = 1'b0;
			vb   = 1'b1;
		end

		// Value byte, escaped or plain
		if (vb) begin
			nmode = M_VALUE;
			if (e_l) begin
				if (z) begin
					lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_VAL, text_byte); n = n + 1'b1;
					fin = 1'b1;
				end else begin
					nesc = 1'b0;
					lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_VAL, text_byte); n = n + 1'b1;
				end
			end else if (z) begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_VAL, text_byte); n = n + 1'b1;
				fin = 1'b1;
			end else if (eol) begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_END, K_VAL, text_byte); n = n + 1'b1;
				disp = 1'b1;
			end else if (text_byte == CH_BSL) begin
				nesc = 1'b1;
			end else begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_VAL, text_byte); n = n + 1'b1;
			end
		end

		// Open the next token, or finish on end of input, from a byte seen between tokens
		if (disp) begin
			nesc = 1'b0;
			if (z) begin
				fin = 1'b1;
			end else if (ws) begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_WS, text_byte); n = n + 1'b1;
				lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_WS, text_byte); n = n + 1'b1;
				nmode = M_WS;
			end else if (text_byte == CH_BANG) begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_BANG, text_byte); n = n + 1'b1;
				nmode = M_BANG;
			end else if (text_byte == CH_POUND) begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_POUND, text_byte); n = n + 1'b1;
				nmode = M_POUND;
			end else begin
				lst[n[IDX_W-1:0]] = mk_entry(EV_START, K_KEY, text_byte); n = n + 1'b1;
				lst[n[IDX_W-1:0]] = mk_entry(EV_DATA, K_KEY, text_byte); n = n + 1'b1;
				nmode = M_KEY;
			end
		end

		// End of parsing
		if (fin) begin
			lst[n[IDX_W-1:0]] = mk_entry(EV_DONE, K_WS, text_byte); n = n + 1'b1;
			nmode = M_DONE;
			nesc  = 1'b0;
		end

		dec.list = lst;
		dec.cnt  = n;
		dec.mode = nmode;
		dec.esc  = nesc;
	end

endmodule

### hdl/properties_file_tokenizer.sv
`timescale 1ns / 1ps

// Channel  Handshake             Word
// in       in_valid / in_ready   text_byte, end_of_input
// out      out_valid / out_ready event_res, token_kind, data, last
//
// A byte waits in the input register, is decoded into up to five
// events that load the result register, and the events leave one per cycle
// while out_ready is high; a new byte is taken in the cycle its
// predecessor's last event goes.
// Bytes after parse done, and escape backslashes, cause no events.
// arst_n clears the parser state and both valid flags; a stalled output
// holds the current event and backs up into the input register.

module properties_file_tokenizer
	import pft_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [2:0] token_kind,
	output logic [7:0] data,
	output logic       last
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eoi_s1;
	logic             valid_s2;
	res_list_t        list_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [IDX_W-1:0] idx_q;
	mode_t            mode_q;
	logic             esc_q;
	dec_t             dec;
	entry_t           cur;
	logic             is_last;
	logic             s2_free;
	logic             xfer;

	pft_decode u_dec (
		.mode         (mode_q),
		.esc          (esc_q),
		.text_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.dec          (dec)
	);

	// Current event and handshake control
	assign cur      = list_s2[idx_q];
	assign is_last  = ({1'b0, idx_q} + 1'b1) == {1'b0, cnt_s2};
	assign s2_free  = !valid_s2 || (out_ready && is_last);
	assign xfer     = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	assign out_valid  = valid_s2;
	assign event_res  = cur.ev;
	assign token_kind = cur.kind;
	assign data       = cur.data;
	assign last       = is_last;

	// Hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// Advance parser state and the result list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= '0;
			idx_q    <= '0;
			mode_q   <= M_START;
			esc_q    <= 1'b0;
		end else begin
			if (xfer) begin
				mode_q   <= dec.mode;
				esc_q    <= dec.esc;
				valid_s2 <= (dec.cnt != '0);
				cnt_s2   <= dec.cnt;
				idx_q    <= '0;
			end else if (valid_s2 && out_ready) begin
				if (is_last) begin
					valid_s2 <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			list_s2 <= dec.list;
		end
	end

`ifndef SYNTHESIS
	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != '0) && ({1'b0, idx_q} < cnt_s2))
		else $error("result list index out of range");

	a_done_no_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_DONE) |-> !esc_q)
		else $error("escape pending after parse done");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("events dropped within one word");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_DONE) |-> last)
		else $error("parse done not final event");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(mode_q) == M_DONE) |-> (mode_q == M_DONE))
		else $error("parser left done state");
`endif

endmodule

### bench/tb_properties_file_tokenizer.sv
`timescale 1ns / 1ps

module tb_properties_file_tokenizer;
	import pft_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 10;
	localparam int RAND_WORDS   = 90;

	typedef struct packed {
		entry_t ent;
		logic   last;
	} tok_word_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic [7:0] text_byte    = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_ready    = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [1:0] event_res;
	logic [2:0] token_kind;
	logic [7:0] data;
	logic       last;

	// predicted parser state
	mode_t      pm   = M_START;
	logic       pesc = 1'b0;
	entry_t     step_q[$];
	tok_word_t  tokens_due[$];
	tok_word_t  due_word;

	int         mismatch_cnt = 0;
	int         words_sent   = 0;
	int         burst_left   = 0;
	int         cycle_cnt    = 0;
	logic [31:0] ready_pat   = 32'hFFFF_FFFF;
	logic [1:0]  ready_mode  = 2'd0;

	properties_file_tokenizer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_input(end_of_input),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.token_kind  (token_kind),
		.data        (data),
		.last        (last)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------

	function automatic bit is_space_byte(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic bit is_eol_byte(logic [7:0] c);
		return c == CH_LF || c == CH_CR;
	endfunction

	function automatic void emit(ev_t ev, kind_t kind, logic [7:0] b);
		entry_t e;
		e.ev   = ev;
		e.kind = kind;
		e.data = 8'h00;
		if (ev == EV_DATA)
			e.data = b;
		step_q.push_back(e);
	endfunction

	function automatic void close_parse();
		emit(EV_DONE, K_WS, 8'h00);
		pm   = M_DONE;
		pesc = 1'b0;
	endfunction

	// Start a token on a byte seen between tokens
	function automatic void open_token(logic [7:0] c, bit z);
		pesc = 1'b0;
		if (z) begin
			close_parse();
		end else if (is_space_byte(c)) begin
			emit(EV_START, K_WS, 8'h00);
			emit(EV_DATA, K_WS, c);
			pm = M_WS;
		end else if (c == CH_BANG) begin
			emit(EV_START, K_BANG, 8'h00);
			pm = M_BANG;
		end else if (c == CH_POUND) begin
			emit(EV_START, K_POUND, 8'h00);
			pm = M_POUND;
		end else begin
			emit(EV_START, K_KEY, 8'h00);
			emit(EV_DATA, K_KEY, c);
			pm = M_KEY;
		end
	endfunction

	function automatic void value_char(logic [7:0] c, bit z);
		pm = M_VALUE;
		if (z) begin
			emit(EV_END, K_VAL, 8'h00);
			close_parse();
		end else if (pesc) begin
			pesc = 1'b0;
			emit(EV_DATA, K_VAL, c);
		end else if (is_eol_byte(c)) begin
			emit(EV_END, K_VAL, 8'h00);
			open_token(c, 1'b0);
		end else if (c == CH_BSL) begin
			pesc = 1'b1;
		end else begin
			emit(EV_DATA, K_VAL, c);
		end
	endfunction

	function automatic void open_val(logic [7:0] c, bit z);
		emit(EV_END, K_SEP, 8'h00);
		emit(EV_START, K_VAL, 8'h00);
		pesc = 1'b0;
		value_char(c, z);
	endfunction

	function automatic void comment_char(kind_t kind, logic [7:0] c, bit z);
		if (z) begin
			emit(EV_END, kind, 8'h00);
			close_parse();
		end else if (is_eol_byte(c)) begin
			emit(EV_END, kind, 8'h00);
			open_token(c, 1'b0);
		end else begin
			emit(EV_DATA, kind, c);
		end
	endfunction

	// Advance the predicted parser by one word and queue the events it causes
	function automatic void predict_tokens(logic [7:0] c, logic eoi);
		bit        z;
		tok_word_t w;
		z = eoi || (c == CH_NUL);
		step_q.delete();
		case (pm)
		M_START: open_token(c, z);
		M_WS: begin
			if (!z && is_space_byte(c)) begin
				emit(EV_DATA, K_WS, c);
			end else begin
				emit(EV_END, K_WS, 8'h00);
				open_token(c, z);
			end
		end
		M_BANG:  comment_char(K_BANG, c, z);
		M_POUND: comment_char(K_POUND, c, z);
		M_KEY: begin
			if (z) begin
				emit(EV_END, K_KEY, 8'h00);
				close_parse();
			end else if (pesc) begin
				pesc = 1'b0;
				emit(EV_DATA, K_KEY, c);
			end else if (c == CH_SPACE) begin
				emit(EV_END, K_KEY, 8'h00);
				emit(EV_START, K_SEP, 8'h00);
				emit(EV_DATA, K_SEP, c);
				pm = M_KSP;
			end else if (c == CH_EQ || c == CH_COLON) begin
				emit(EV_END, K_KEY, 8'h00);
				emit(EV_START, K_SEP, 8'h00);
				emit(EV_DATA, K_SEP, c);
				emit(EV_END, K_SEP, 8'h00);
				emit(EV_START, K_VAL, 8'h00);
				pm = M_VALUE;
			end else if (is_eol_byte(c)) begin
				emit(EV_END, K_KEY, 8'h00);
				open_token(c, 1'b0);
			end else if (c == CH_BSL) begin
				pesc = 1'b1;
			end else begin
				emit(EV_DATA, K_KEY, c);
			end
		end
		M_KSP: begin
			if (!z && (c == CH_EQ || c == CH_COLON)) begin
				emit(EV_DATA, K_SEP, c);
				pm = M_SEP2;
			end else begin
				open_val(c, z);
			end
		end
		M_SEP2, M_SEP3: begin
			if (z || is_eol_byte(c)) begin
				emit(EV_END, K_SEP, 8'h00);
				open_token(c, z);
			end else if (pm == M_SEP2 && c == CH_SPACE) begin
				emit(EV_DATA, K_SEP, c);
				pm = M_SEP3;
			end else begin
				open_val(c, 1'b0);
			end
		end
		M_VALUE: value_char(c, z);
		default: begin
			pm   = M_DONE;
			pesc = 1'b0;
		end
		endcase
		// flag the final event of this word
		foreach (step_q[i]) begin
			w.ent  = step_q[i];
			w.last = (i == step_q.size() - 1);
			tokens_due.push_back(w);
		end
	endfunction

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------

	// Present one word, idling for a random gap (possibly none) first when a burst has run out
	task automatic send_word(input logic [7:0] b, input logic eoi);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		text_byte    <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		predict_tokens(b, eoi);
	endtask

	// Hold the sender until every predicted event has come out
	task automatic wait_for_tokens();
		in_valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_text_byte();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(32, 126));
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] rand_ws_byte();
		case ($urandom_range(0, 5))
		0:       return CH_SPACE;
		1:       return CH_TAB;
		2:       return CH_LF;
		3:       return CH_VT;
		4:       return CH_FF;
		default: return CH_CR;
		endcase
	endfunction

	// Key or value text with an occasional escape
	task automatic send_body(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0)
				send_word(CH_BSL, 1'b0);
			send_word(rand_text_byte(), 1'b0);
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// A whitespace run of space, tab, VT and FF, then both comment styles, ended by LF and CR
	task automatic test_whitespace_and_comments();
		send_word(CH_SPACE, 1'b0);
		send_word(CH_TAB, 1'b0);
		send_word(CH_VT, 1'b0);
		send_word(CH_FF, 1'b0);
		send_word(CH_BANG, 1'b0);
		send_word("a", 1'b0);
		send_word(CH_LF, 1'b0);
		send_word(CH_POUND, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(CH_CR, 1'b0);
	endtask

	task automatic test_keys_and_separators();
		// backslash as first key byte, escaped '=', direct ':' with empty value
		send_word(CH_BSL, 1'b0);
		send_word(CH_BSL, 1'b0);
		send_word(CH_EQ, 1'b0);
		send_word(CH_COLON, 1'b0);
		send_word(CH_LF, 1'b0);
		// single space separator, next byte opens the value
		send_word("k", 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word("v", 1'b0);
		send_word(CH_CR, 1'b0);
		// '=' as first key byte, space and '=' then line end: no value
		send_word(CH_EQ, 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word(CH_EQ, 1'b0);
		send_word(CH_LF, 1'b0);
		// longest separator form
		send_word("k", 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word(CH_COLON, 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word("w", 1'b0);
		send_word(CH_CR, 1'b0);
	endtask

	// Mostly well-formed lines with random content, plus some noise
	task automatic test_random_lines();
		int stop_at;
		int n;
		logic [7:0] b;
		stop_at = words_sent + RAND_WORDS;
		while (words_sent < stop_at) begin
			case ($urandom_range(0, 9))
			0: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_word(rand_ws_byte(), 1'b0);
			end
			1: begin
				send_word($urandom_range(0, 1) ? CH_BANG : CH_POUND, 1'b0);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++)
					send_word(rand_text_byte(), 1'b0);
				send_word($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
			end
			8, 9: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					send_word(8'($urandom_range(1, 255)), 1'b0);
			end
			default: begin
				do
					b = rand_text_byte();
				while (is_space_byte(b) || b == CH_BANG || b == CH_POUND);
				send_word(b, 1'b0);
				send_body($urandom_range(0, 4));
				case ($urandom_range(0, 5))
				0: send_word(CH_EQ, 1'b0);
				1: send_word(CH_COLON, 1'b0);
				2: send_word(CH_SPACE, 1'b0);
				3: begin
					send_word(CH_SPACE, 1'b0);
					send_word(CH_EQ, 1'b0);
				end
				4: begin
					send_word(CH_SPACE, 1'b0);
					send_word(CH_COLON, 1'b0);
					send_word(CH_SPACE, 1'b0);
				end
				default: begin
					send_word(CH_SPACE, 1'b0);
					send_word(CH_EQ, 1'b0);
					send_word(CH_SPACE, 1'b0);
				end
				endcase
				send_body($urandom_range(0, 6));
				if ($urandom_range(0, 7) != 0)
					send_word($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
			end
			endcase
		end
	endtask

	// Escape pending at end of input, then words that must be ignored
	task automatic test_end_of_input();
		send_word(CH_LF, 1'b0);
		send_word(CH_LF, 1'b0);
		send_word("z", 1'b0);
		send_word(CH_BSL, 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
		send_word(CH_NUL, 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
		send_word(8'($urandom_range(1, 255)), 1'b0);
	endtask

	// ---------------------------------------------------------------
	// Receiver and checker
	// ---------------------------------------------------------------

	task automatic note_mismatch(input string what, input tok_word_t want);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t %s: expected ev=%0d kind=%0d data=%02h last=%0b, %s",
				$realtime, what, want.ent.ev, want.ent.kind, want.ent.data, want.last,
				$sformatf("got ev=%0d kind=%0d data=%02h last=%0b",
					event_res, token_kind, data, last));
	endtask

	// Compare each accepted word, then drive the stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tokens_due.size() == 0) begin
				note_mismatch("unexpected word", '0);
			end else begin
				due_word = tokens_due.pop_front();
				if (due_word.ent.ev !== event_res || due_word.ent.kind !== token_kind ||
					due_word.ent.data !== data || due_word.last !== last)
					note_mismatch("mismatch", due_word);
			end
		end
		if (cycle_cnt[5:0] == 6'd0) begin
			ready_pat  <= $urandom;
			ready_mode <= 2'($urandom_range(0, 3));
		end
		case (ready_mode)
		2'd0:    out_ready <= 1'b1;
		2'd1:    out_ready <= ready_pat[cycle_cnt[4:0]];
		2'd2:    out_ready <= ready_pat[cycle_cnt[4:0]] | ready_pat[cycle_cnt[4:0] + 5'd1];
		default: out_ready <= ready_pat[cycle_cnt[4:0]] & ready_pat[cycle_cnt[4:0] + 5'd3];
		endcase
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL properties_file_tokenizer");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_whitespace_and_comments();
		wait_for_tokens();
		test_keys_and_separators();
		wait_for_tokens();
		test_random_lines();
		wait_for_tokens();
		test_end_of_input();
		wait_for_tokens();
		if (mismatch_cnt == 0)
			$display("PASS properties_file_tokenizer");
		else
			$display("FAIL properties_file_tokenizer");
		$finish;
	end

endmodule
